// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the rectangle placement engine RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RPE_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error("check failed");
`define RPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error("check failed");
`else
`define RPE_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define RPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/rpe_pkg.sv =====
// Shared types, codes and helper functions for the rectangle placement engine.
// No dependencies.
package rpe_pkg;

  localparam int DEF_MAX_TYPES = 16;
  localparam int DEF_MAX_SPOTS = 64;
  localparam int DEF_MAX_PARTS = 256;

  localparam int COORD_BITS = 16;
  localparam int WIDE_BITS  = COORD_BITS + 3;
  localparam int FAIL_BITS  = 9;
  localparam int FIT_BITS   = 32;
  localparam int AREA_BITS  = 32;
  localparam int DVS_BITS   = 2 * COORD_BITS;
  localparam int DVD_BITS   = AREA_BITS + 16;
  localparam int DIV_CNT_BITS = $clog2(DVD_BITS + 1);

  localparam logic [FAIL_BITS-1:0] FAIL_MAX = '1;
  localparam logic [FIT_BITS-1:0]  FIT_SAT  = 32'h7FFF_FFFF;
  localparam logic [COORD_BITS-1:0] RESET_SHEET = COORD_BITS'(1000);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;

  localparam wide_t COORD_MAX_W = wide_t'((64'd1 << COORD_BITS) - 64'd1);

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t mx;
    coord_t my;
  } spot_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } part_t;

  typedef struct packed {
    coord_t w;
    coord_t h;
  } type_ent_t;

  typedef enum logic [1:0] {
    OP_WRITE_TYPE = 2'd0,
    OP_BEGIN      = 2'd1,
    OP_PLACE      = 2'd2,
    OP_FINISH     = 2'd3
  } op_t;

  localparam logic [2:0] CFG_SHEET_W    = 3'd0;
  localparam logic [2:0] CFG_SHEET_H    = 3'd1;
  localparam logic [2:0] CFG_PACK_MODE  = 3'd2;
  localparam logic [2:0] CFG_TYPE_COUNT = 3'd3;
  localparam logic [2:0] CFG_AREA_TOTAL = 3'd4;

  localparam logic [2:0] MODE_ROWS   = 3'd0;
  localparam logic [2:0] MODE_COLS   = 3'd1;
  localparam logic [2:0] MODE_DIAG   = 3'd2;
  localparam logic [2:0] MODE_SQUARE = 3'd3;
  localparam logic [2:0] MODE_CORNER_UNSORTED = 3'd5;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_RESP,
    ST_P_TYPE, ST_P_SCAN_RD, ST_P_SCAN_CHK, ST_P_SHIFT_RD, ST_P_SHIFT_WR,
    ST_P_UPD, ST_P_PUSH,
    ST_C_RD, ST_C_LD, ST_C_PRD, ST_C_PAPPLY, ST_C_TRD, ST_C_TCHK, ST_C_WR,
    ST_S_IRD, ST_S_ILD, ST_S_KRD, ST_S_KCMP, ST_S_PUT,
    ST_F_MUL, ST_F_SUB, ST_F_DIV
  } state_t;

  typedef struct packed {
    logic                start;
    logic [DVD_BITS-1:0] dividend;
    logic [DVS_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DVD_BITS-1:0] quotient;
  } div_rsp_t;

  function automatic wide_t wz(input coord_t c);
    return signed'({3'b000, c});
  endfunction

  function automatic coord_t clampc(input wide_t v);
    coord_t r;
    if (v < 0) r = '0;
    else if (v > COORD_MAX_W) r = '1;
    else r = v[COORD_BITS-1:0];
    return r;
  endfunction

  function automatic logic tracks_corner(input logic [2:0] mode);
    return (mode == MODE_DIAG) || (mode == MODE_CORNER_UNSORTED);
  endfunction

  // One clipping step of a spot against a placed part.
  function automatic spot_t spot_clip(input spot_t s, input part_t d);
    spot_t r;
    logic [COORD_BITS:0] ye, xe;
    logic in_x, in_y;
    r    = s;
    ye   = {1'b0, d.y} + {1'b0, d.h};
    xe   = {1'b0, d.x} + {1'b0, d.w};
    in_y = (s.y >= d.y) && ({1'b0, s.y} < ye);
    in_x = (s.x >= d.x) && ({1'b0, s.x} < xe);
    if ((s.x <= d.x) && in_y && ((d.x - s.x) < r.mx)) r.mx = d.x - s.x;
    if ((s.y <= d.y) && in_x && ((d.y - s.y) < r.my)) r.my = d.y - s.y;
    if (in_x && in_y) begin
      r.mx = '0;
      r.my = '0;
    end
    return r;
  endfunction

  function automatic logic type_fits(input spot_t s, input type_ent_t t);
    return ((s.mx >= t.w) && (s.my >= t.h)) || ((s.mx >= t.h) && (s.my >= t.w));
  endfunction

  function automatic logic spot_less(input spot_t a, input spot_t b, input logic [2:0] mode);
    logic   rows;
    logic   r;
    coord_t ka, kb;
    rows = (a.y != b.y) ? (a.y < b.y) : (a.x < b.x);
    ka   = '0;
    kb   = '0;
    unique case (mode)
      MODE_ROWS: r = rows;
      MODE_COLS: r = (a.x != b.x) ? (a.x < b.x) : (a.y < b.y);
      MODE_DIAG: begin
        ka = (a.x < a.y) ? a.x : a.y;
        kb = (b.x < b.y) ? b.x : b.y;
        r  = (ka != kb) ? (ka < kb) : rows;
      end
      MODE_SQUARE: begin
        ka = (a.x > a.y) ? a.x : a.y;
        kb = (b.x > b.y) ? b.x : b.y;
        r  = (ka != kb) ? (ka < kb) : rows;
      end
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/rpe_div.sv =====
// Restoring divider, one quotient bit per cycle, for the fitness quotient.
// Depends on rpe_pkg.
module rpe_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rpe_pkg::div_req_t req,
  output rpe_pkg::div_rsp_t rsp
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [rpe_pkg::DIV_CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic [rpe_pkg::DVD_BITS-1:0]        quo_r, quo_nxt;
  logic [rpe_pkg::DVS_BITS-1:0]        rem_r, rem_nxt;
  logic [rpe_pkg::DVS_BITS-1:0]        dvs_r, dvs_nxt;
  logic [rpe_pkg::DVS_BITS:0]          trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[rpe_pkg::DVD_BITS-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = rpe_pkg::DIV_CNT_BITS'(rpe_pkg::DVD_BITS);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = rpe_pkg::DVS_BITS'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[rpe_pkg::DVD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[rpe_pkg::DVS_BITS-1:0];
        quo_nxt = {quo_r[rpe_pkg::DVD_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - rpe_pkg::DIV_CNT_BITS'(1);
      if (cnt_r == rpe_pkg::DIV_CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/core/rectangle_placement_engine_unit.sv =====
// Top level of the rectangle placement engine: sequencer, spot/part/type memories.
// Depends on rpe_pkg, rpe_div and assert_macros.svh.
//
// Usage: configuration registers are written through cfg_we/cfg_index/cfg_wdata
// while the block is idle. Commands arrive on the in_ valid/ready channel, one
// at a time; every command gives exactly one transfer on the out_ channel.
// Steps per command:
//   write type, begin, a refused place and a finish after failures go from
//   idle straight to the response. place: type read, first-fit scan and shift
//   of the spot memory, 4 pushes, then a clip pass of every spot against each
//   placed part and type and, in modes 0..3, an insertion sort on the spot memory.
//   finish: multiply and subtract, then the serial divider.
// The next command is taken as soon as the last result sits in the output
// register, not before, even if the receiver stalls. A second result waits
// in the sequencer until out_ready frees the register.
// Reset: synchronous, active low; control registers take their reset values
// and the first cycle after reset writes the full-sheet spot, with in_ready low.
`include "assert_macros.svh"
module rectangle_placement_engine_unit #(
  parameter int MAX_TYPES = rpe_pkg::DEF_MAX_TYPES,
  parameter int MAX_SPOTS = rpe_pkg::DEF_MAX_SPOTS,
  parameter int MAX_PARTS = rpe_pkg::DEF_MAX_PARTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_type_index,
  input  logic [15:0] in_type_width,
  input  logic [15:0] in_type_height,
  input  logic        in_rotated,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_placed,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic [15:0] out_bound_width,
  output logic [15:0] out_bound_height,
  output logic signed [31:0] out_fitness_q16,
  output logic        out_spot_overflow
);

  localparam int TAW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int TCW = $clog2(MAX_TYPES + 1);
  localparam int SAW = $clog2(MAX_SPOTS);
  localparam int SCW = $clog2(MAX_SPOTS + 1);
  localparam int PAW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int PCW = $clog2(MAX_PARTS + 1);

  // memories
  rpe_pkg::type_ent_t type_mem [MAX_TYPES];
  rpe_pkg::spot_t     spot_mem [MAX_SPOTS];
  rpe_pkg::part_t     part_mem [MAX_PARTS];

  rpe_pkg::type_ent_t type_rd_r, type_wd;
  rpe_pkg::spot_t     spot_rd_r, spot_wd;
  rpe_pkg::part_t     part_rd_r, part_wd;
  logic               type_we, spot_we, part_we;
  logic [TAW-1:0]     type_wa, type_ra;
  logic [SAW-1:0]     spot_wa, spot_ra;
  logic [PAW-1:0]     part_wa, part_ra;

  rpe_pkg::state_t    state_r, state_nxt;
  rpe_pkg::coord_t    sheet_w_r, sheet_w_nxt, sheet_h_r, sheet_h_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic [4:0]         tcount_r, tcount_nxt;
  logic [rpe_pkg::AREA_BITS-1:0] area_r, area_nxt;
  logic [SCW-1:0]     spot_cnt_r, spot_cnt_nxt;
  logic [PCW-1:0]     parts_cnt_r, parts_cnt_nxt;
  logic [rpe_pkg::FAIL_BITS-1:0] fail_r, fail_nxt, fail_inc;
  rpe_pkg::coord_t    ext_x_r, ext_x_nxt, ext_y_r, ext_y_nxt;
  rpe_pkg::coord_t    free_x_r, free_x_nxt, free_y_r, free_y_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               rot_r, rot_nxt;
  rpe_pkg::coord_t    w_r, w_nxt, h_r, h_nxt, x_r, x_nxt, y_r, y_nxt;
  logic [SCW-1:0]     i_r, i_nxt, k_r, k_nxt, o_r, o_nxt, km1;
  logic [PCW-1:0]     j_r, j_nxt;
  logic [TCW-1:0]     t_r, t_nxt, nt;
  logic [1:0]         n_r, n_nxt;
  rpe_pkg::spot_t     s_r, s_nxt, key_r, key_nxt, push_spot;
  logic               keep_r, keep_nxt;
  logic               res_placed_r, res_placed_nxt;
  rpe_pkg::coord_t    res_px_r, res_px_nxt, res_py_r, res_py_nxt;
  logic [rpe_pkg::FIT_BITS-1:0] res_fit_r, res_fit_nxt;
  logic [rpe_pkg::DVS_BITS-1:0] prod1_r, prod1_nxt, prod2_r, prod2_nxt, denom;

  logic               o_placed_r, o_placed_nxt, o_ovf_r, o_ovf_nxt;
  rpe_pkg::coord_t    o_px_r, o_px_nxt, o_py_r, o_py_nxt;
  rpe_pkg::coord_t    o_bw_r, o_bw_nxt, o_bh_r, o_bh_nxt;
  logic [rpe_pkg::FIT_BITS-1:0] o_fit_r, o_fit_nxt;

  rpe_pkg::coord_t    xw_c, yh_c, ext_x_new, ext_y_new;
  logic [rpe_pkg::COORD_BITS:0] xw_s, yh_s;

  rpe_pkg::div_req_t  div_req;
  rpe_pkg::div_rsp_t  div_rsp;

  rpe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == rpe_pkg::ST_IDLE);
  assign fail_inc = (fail_r == rpe_pkg::FAIL_MAX) ? fail_r
                                                   : fail_r + rpe_pkg::FAIL_BITS'(1);
  assign nt  = (32'(tcount_r) > MAX_TYPES) ? TCW'(MAX_TYPES) : TCW'(tcount_r);
  assign km1 = k_r - SCW'(1);
  assign denom = prod1_r - prod2_r;

  assign xw_s = {1'b0, x_r} + {1'b0, w_r};
  assign yh_s = {1'b0, y_r} + {1'b0, h_r};
  assign xw_c = rpe_pkg::clampc(rpe_pkg::wz(x_r) + rpe_pkg::wz(w_r));
  assign yh_c = rpe_pkg::clampc(rpe_pkg::wz(y_r) + rpe_pkg::wz(h_r));
  assign ext_x_new = (xw_c > ext_x_r) ? xw_c : ext_x_r;
  assign ext_y_new = (yh_c > ext_y_r) ? yh_c : ext_y_r;

  always_comb begin
    unique case (n_r)
      2'd0: push_spot = '{x: '0,
                          y: ext_y_r,
                          mx: sheet_w_r,
                          my: rpe_pkg::clampc(rpe_pkg::wz(sheet_h_r) - rpe_pkg::wz(ext_y_r))};
      2'd1: push_spot = '{x: ext_x_r,
                          y: '0,
                          mx: rpe_pkg::clampc(rpe_pkg::wz(sheet_w_r) - rpe_pkg::wz(ext_x_r)),
                          my: sheet_h_r};
      2'd2: push_spot = '{x: xw_c,
                          y: y_r,
                          mx: rpe_pkg::clampc(rpe_pkg::wz(sheet_w_r) - rpe_pkg::wz(x_r)
                                              - rpe_pkg::wz(w_r)),
                          my: rpe_pkg::clampc(rpe_pkg::wz(sheet_h_r) - rpe_pkg::wz(y_r))};
      default: push_spot = '{x: x_r,
                             y: yh_c,
                             mx: rpe_pkg::clampc(rpe_pkg::wz(sheet_w_r) - rpe_pkg::wz(x_r)),
                             my: rpe_pkg::clampc(rpe_pkg::wz(sheet_h_r) - rpe_pkg::wz(y_r)
                                                 - rpe_pkg::wz(h_r))};
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    sheet_w_nxt   = sheet_w_r;
    sheet_h_nxt   = sheet_h_r;
    mode_nxt      = mode_r;
    tcount_nxt    = tcount_r;
    area_nxt      = area_r;
    spot_cnt_nxt  = spot_cnt_r;
    parts_cnt_nxt = parts_cnt_r;
    fail_nxt      = fail_r;
    ext_x_nxt     = ext_x_r;
    ext_y_nxt     = ext_y_r;
    free_x_nxt    = free_x_r;
    free_y_nxt    = free_y_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    rot_nxt       = rot_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    o_nxt         = o_r;
    j_nxt         = j_r;
    t_nxt         = t_r;
    n_nxt         = n_r;
    s_nxt         = s_r;
    key_nxt       = key_r;
    keep_nxt      = keep_r;
    res_placed_nxt = res_placed_r;
    res_px_nxt    = res_px_r;
    res_py_nxt    = res_py_r;
    res_fit_nxt   = res_fit_r;
    prod1_nxt     = prod1_r;
    prod2_nxt     = prod2_r;
    o_placed_nxt  = o_placed_r;
    o_px_nxt      = o_px_r;
    o_py_nxt      = o_py_r;
    o_bw_nxt      = o_bw_r;
    o_bh_nxt      = o_bh_r;
    o_fit_nxt     = o_fit_r;
    o_ovf_nxt     = o_ovf_r;
    type_we = 1'b0;
    type_wa = '0;
    type_wd = '0;
    type_ra = '0;
    spot_we = 1'b0;
    spot_wa = '0;
    spot_wd = '0;
    spot_ra = '0;
    part_we = 1'b0;
    part_wa = '0;
    part_wd = '0;
    part_ra = '0;
    div_req = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        rpe_pkg::CFG_SHEET_W:    sheet_w_nxt = cfg_wdata[15:0];
        rpe_pkg::CFG_SHEET_H:    sheet_h_nxt = cfg_wdata[15:0];
        rpe_pkg::CFG_PACK_MODE:  mode_nxt    = cfg_wdata[2:0];
        rpe_pkg::CFG_TYPE_COUNT: tcount_nxt  = cfg_wdata[4:0];
        rpe_pkg::CFG_AREA_TOTAL: area_nxt    = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      rpe_pkg::ST_INIT: begin
        spot_we   = 1'b1;
        spot_wd   = '{x: '0, y: '0, mx: rpe_pkg::RESET_SHEET, my: rpe_pkg::RESET_SHEET};
        state_nxt = rpe_pkg::ST_IDLE;
      end
      rpe_pkg::ST_IDLE: begin
        if (in_valid) begin
          rot_nxt        = in_rotated;
          res_placed_nxt = 1'b0;
          res_px_nxt     = '0;
          res_py_nxt     = '0;
          res_fit_nxt    = '0;
          state_nxt      = rpe_pkg::ST_RESP;
          unique case (rpe_pkg::op_t'(in_operation))
            rpe_pkg::OP_WRITE_TYPE: begin
              if (32'(in_type_index) < MAX_TYPES) begin
                type_we = 1'b1;
                type_wa = TAW'(in_type_index);
                type_wd = '{w: in_type_width, h: in_type_height};
              end
            end
            rpe_pkg::OP_BEGIN: begin
              spot_we       = 1'b1;
              spot_wd       = '{x: '0, y: '0, mx: sheet_w_r, my: sheet_h_r};
              spot_cnt_nxt  = SCW'(1);
              ovf_nxt       = 1'b0;
              parts_cnt_nxt = '0;
              fail_nxt      = '0;
              ext_x_nxt     = '0;
              ext_y_nxt     = '0;
              free_x_nxt    = '0;
              free_y_nxt    = '0;
            end
            rpe_pkg::OP_PLACE: begin
              if ((32'(in_type_index) >= MAX_TYPES) || (parts_cnt_r >= PCW'(MAX_PARTS))) begin
                fail_nxt = fail_inc;
              end else begin
                type_ra   = TAW'(in_type_index);
                state_nxt = rpe_pkg::ST_P_TYPE;
              end
            end
            rpe_pkg::OP_FINISH: begin
              if (fail_r != '0) res_fit_nxt = -{23'b0, fail_r};
              else state_nxt = rpe_pkg::ST_F_MUL;
            end
          endcase
        end
      end
      rpe_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_placed_nxt  = res_placed_r;
          o_px_nxt      = res_px_r;
          o_py_nxt      = res_py_r;
          o_bw_nxt      = ext_x_r;
          o_bh_nxt      = ext_y_r;
          o_fit_nxt     = res_fit_r;
          o_ovf_nxt     = ovf_r;
          state_nxt     = rpe_pkg::ST_IDLE;
        end
      end
      rpe_pkg::ST_P_TYPE: begin
        w_nxt     = rot_r ? type_rd_r.h : type_rd_r.w;
        h_nxt     = rot_r ? type_rd_r.w : type_rd_r.h;
        i_nxt     = '0;
        state_nxt = rpe_pkg::ST_P_SCAN_RD;
      end
      rpe_pkg::ST_P_SCAN_RD: begin
        if (i_r == spot_cnt_r) begin
          fail_nxt  = fail_inc;
          state_nxt = rpe_pkg::ST_RESP;
        end else begin
          spot_ra   = i_r[SAW-1:0];
          state_nxt = rpe_pkg::ST_P_SCAN_CHK;
        end
      end
      rpe_pkg::ST_P_SCAN_CHK: begin
        if ((spot_rd_r.mx >= w_r) && (spot_rd_r.my >= h_r)) begin
          x_nxt     = spot_rd_r.x;
          y_nxt     = spot_rd_r.y;
          k_nxt     = i_r + SCW'(1);
          state_nxt = rpe_pkg::ST_P_SHIFT_RD;
        end else begin
          i_nxt     = i_r + SCW'(1);
          state_nxt = rpe_pkg::ST_P_SCAN_RD;
        end
      end
      rpe_pkg::ST_P_SHIFT_RD: begin
        if (k_r == spot_cnt_r) begin
          spot_cnt_nxt = spot_cnt_r - SCW'(1);
          state_nxt    = rpe_pkg::ST_P_UPD;
        end else begin
          spot_ra   = k_r[SAW-1:0];
          state_nxt = rpe_pkg::ST_P_SHIFT_WR;
        end
      end
      rpe_pkg::ST_P_SHIFT_WR: begin
        spot_we   = 1'b1;
        spot_wa   = km1[SAW-1:0];
        spot_wd   = spot_rd_r;
        k_nxt     = k_r + SCW'(1);
        state_nxt = rpe_pkg::ST_P_SHIFT_RD;
      end
      rpe_pkg::ST_P_UPD: begin
        ext_x_nxt = ext_x_new;
        ext_y_nxt = ext_y_new;
        if (rpe_pkg::tracks_corner(mode_r)) begin
          if (xw_s > yh_s) free_y_nxt = (yh_c > free_y_r) ? yh_c : free_y_r;
          else free_x_nxt = (xw_c > free_x_r) ? xw_c : free_x_r;
        end else begin
          free_x_nxt = ext_x_new;
          free_y_nxt = ext_y_new;
        end
        part_we        = 1'b1;
        part_wa        = parts_cnt_r[PAW-1:0];
        part_wd        = '{x: x_r, y: y_r, w: w_r, h: h_r};
        parts_cnt_nxt  = parts_cnt_r + PCW'(1);
        res_placed_nxt = 1'b1;
        res_px_nxt     = x_r;
        res_py_nxt     = y_r;
        n_nxt          = '0;
        state_nxt      = rpe_pkg::ST_P_PUSH;
      end
      rpe_pkg::ST_P_PUSH: begin
        if (spot_cnt_r >= SCW'(MAX_SPOTS)) begin
          ovf_nxt = 1'b1;
        end else begin
          spot_we      = 1'b1;
          spot_wa      = spot_cnt_r[SAW-1:0];
          spot_wd      = push_spot;
          spot_cnt_nxt = spot_cnt_r + SCW'(1);
        end
        if (n_r == 2'd3) begin
          i_nxt     = '0;
          o_nxt     = '0;
          state_nxt = rpe_pkg::ST_C_RD;
        end else begin
          n_nxt = n_r + 2'd1;
        end
      end
      rpe_pkg::ST_C_RD: begin
        if (i_r == spot_cnt_r) begin
          spot_cnt_nxt = o_r;
          if (mode_r <= rpe_pkg::MODE_SQUARE) begin
            i_nxt     = SCW'(1);
            state_nxt = rpe_pkg::ST_S_IRD;
          end else begin
            state_nxt = rpe_pkg::ST_RESP;
          end
        end else begin
          spot_ra   = i_r[SAW-1:0];
          state_nxt = rpe_pkg::ST_C_LD;
        end
      end
      rpe_pkg::ST_C_LD: begin
        s_nxt     = spot_rd_r;
        j_nxt     = '0;
        state_nxt = rpe_pkg::ST_C_PRD;
      end
      rpe_pkg::ST_C_PRD: begin
        if (j_r == parts_cnt_r) begin
          t_nxt     = '0;
          keep_nxt  = 1'b0;
          state_nxt = rpe_pkg::ST_C_TRD;
        end else begin
          part_ra   = j_r[PAW-1:0];
          state_nxt = rpe_pkg::ST_C_PAPPLY;
        end
      end
      rpe_pkg::ST_C_PAPPLY: begin
        s_nxt     = rpe_pkg::spot_clip(s_r, part_rd_r);
        j_nxt     = j_r + PCW'(1);
        state_nxt = rpe_pkg::ST_C_PRD;
      end
      rpe_pkg::ST_C_TRD: begin
        if (t_r == nt) begin
          state_nxt = rpe_pkg::ST_C_WR;
        end else begin
          type_ra   = t_r[TAW-1:0];
          state_nxt = rpe_pkg::ST_C_TCHK;
        end
      end
      rpe_pkg::ST_C_TCHK: begin
        if (rpe_pkg::type_fits(s_r, type_rd_r)) keep_nxt = 1'b1;
        t_nxt     = t_r + TCW'(1);
        state_nxt = rpe_pkg::ST_C_TRD;
      end
      rpe_pkg::ST_C_WR: begin
        if (keep_r) begin
          spot_we = 1'b1;
          spot_wa = o_r[SAW-1:0];
          spot_wd = s_r;
          o_nxt   = o_r + SCW'(1);
        end
        i_nxt     = i_r + SCW'(1);
        state_nxt = rpe_pkg::ST_C_RD;
      end
      rpe_pkg::ST_S_IRD: begin
        if (i_r >= spot_cnt_r) begin
          state_nxt = rpe_pkg::ST_RESP;
        end else begin
          spot_ra   = i_r[SAW-1:0];
          state_nxt = rpe_pkg::ST_S_ILD;
        end
      end
      rpe_pkg::ST_S_ILD: begin
        key_nxt   = spot_rd_r;
        k_nxt     = i_r;
        state_nxt = rpe_pkg::ST_S_KRD;
      end
      rpe_pkg::ST_S_KRD: begin
        if (k_r == '0) begin
          state_nxt = rpe_pkg::ST_S_PUT;
        end else begin
          spot_ra   = km1[SAW-1:0];
          state_nxt = rpe_pkg::ST_S_KCMP;
        end
      end
      rpe_pkg::ST_S_KCMP: begin
        if (rpe_pkg::spot_less(key_r, spot_rd_r, mode_r)) begin
          spot_we   = 1'b1;
          spot_wa   = k_r[SAW-1:0];
          spot_wd   = spot_rd_r;
          k_nxt     = km1;
          state_nxt = rpe_pkg::ST_S_KRD;
        end else begin
          state_nxt = rpe_pkg::ST_S_PUT;
        end
      end
      rpe_pkg::ST_S_PUT: begin
        spot_we   = 1'b1;
        spot_wa   = k_r[SAW-1:0];
        spot_wd   = key_r;
        i_nxt     = i_r + SCW'(1);
        state_nxt = rpe_pkg::ST_S_IRD;
      end
      rpe_pkg::ST_F_MUL: begin
        prod1_nxt = ext_x_r * ext_y_r;
        if (rpe_pkg::tracks_corner(mode_r))
          prod2_nxt = (ext_x_r - free_x_r) * (ext_y_r - free_y_r);
        else
          prod2_nxt = '0;
        state_nxt = rpe_pkg::ST_F_SUB;
      end
      rpe_pkg::ST_F_SUB: begin
        if (denom == '0) begin
          res_fit_nxt = rpe_pkg::FIT_SAT;
          state_nxt   = rpe_pkg::ST_RESP;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {area_r, 16'b0};
          div_req.divisor  = denom;
          state_nxt        = rpe_pkg::ST_F_DIV;
        end
      end
      rpe_pkg::ST_F_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient > rpe_pkg::DVD_BITS'(rpe_pkg::FIT_SAT))
            res_fit_nxt = rpe_pkg::FIT_SAT;
          else
            res_fit_nxt = div_rsp.quotient[rpe_pkg::FIT_BITS-1:0];
          state_nxt = rpe_pkg::ST_RESP;
        end
      end
      default: state_nxt = rpe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpe_pkg::ST_INIT;
      sheet_w_r   <= rpe_pkg::RESET_SHEET;
      sheet_h_r   <= rpe_pkg::RESET_SHEET;
      mode_r      <= rpe_pkg::MODE_SQUARE;
      tcount_r    <= 5'd1;
      area_r      <= '0;
      spot_cnt_r  <= SCW'(1);
      parts_cnt_r <= '0;
      fail_r      <= '0;
      ext_x_r     <= '0;
      ext_y_r     <= '0;
      free_x_r    <= '0;
      free_y_r    <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sheet_w_r   <= sheet_w_nxt;
      sheet_h_r   <= sheet_h_nxt;
      mode_r      <= mode_nxt;
      tcount_r    <= tcount_nxt;
      area_r      <= area_nxt;
      spot_cnt_r  <= spot_cnt_nxt;
      parts_cnt_r <= parts_cnt_nxt;
      fail_r      <= fail_nxt;
      ext_x_r     <= ext_x_nxt;
      ext_y_r     <= ext_y_nxt;
      free_x_r    <= free_x_nxt;
      free_y_r    <= free_y_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rot_r        <= rot_nxt;
    w_r          <= w_nxt;
    h_r          <= h_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    i_r          <= i_nxt;
    k_r          <= k_nxt;
    o_r          <= o_nxt;
    j_r          <= j_nxt;
    t_r          <= t_nxt;
    n_r          <= n_nxt;
    s_r          <= s_nxt;
    key_r        <= key_nxt;
    keep_r       <= keep_nxt;
    res_placed_r <= res_placed_nxt;
    res_px_r     <= res_px_nxt;
    res_py_r     <= res_py_nxt;
    res_fit_r    <= res_fit_nxt;
    prod1_r      <= prod1_nxt;
    prod2_r      <= prod2_nxt;
    o_placed_r   <= o_placed_nxt;
    o_px_r       <= o_px_nxt;
    o_py_r       <= o_py_nxt;
    o_bw_r       <= o_bw_nxt;
    o_bh_r       <= o_bh_nxt;
    o_fit_r      <= o_fit_nxt;
    o_ovf_r      <= o_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (type_we) type_mem[type_wa] <= type_wd;
    type_rd_r <= type_mem[type_ra];
  end

  always_ff @(posedge clk) begin
    if (spot_we) spot_mem[spot_wa] <= spot_wd;
    spot_rd_r <= spot_mem[spot_ra];
  end

  always_ff @(posedge clk) begin
    if (part_we) part_mem[part_wa] <= part_wd;
    part_rd_r <= part_mem[part_ra];
  end

  assign out_valid         = out_valid_r;
  assign out_placed        = o_placed_r;
  assign out_pos_x         = o_px_r;
  assign out_pos_y         = o_py_r;
  assign out_bound_width   = o_bw_r;
  assign out_bound_height  = o_bh_r;
  assign out_fitness_q16   = signed'(o_fit_r);
  assign out_spot_overflow = o_ovf_r;

  `RPE_ASSERT_ALWAYS(a_spot_cnt_bound, clk, rst_n, spot_cnt_r <= SCW'(MAX_SPOTS))
  `RPE_ASSERT_ALWAYS(a_parts_cnt_bound, clk, rst_n, parts_cnt_r <= PCW'(MAX_PARTS))
  `RPE_ASSERT_ALWAYS(a_corner_in_box, clk, rst_n, (free_x_r <= ext_x_r) && (free_y_r <= ext_y_r))
  `RPE_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule
